// File: design/aabb_frustum_cull_defines.svh
// Assertion macros used by the checker file of the culling block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// Same-cycle implication.
`define AFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("culling checker: assertion failed");

// Next-cycle implication.
`define AFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("culling checker: assertion failed");

`endif

// File: design/afc_pkg.sv
package afc_pkg;

  localparam int unsigned AFC_COORD_W        = 16;
  localparam int unsigned AFC_NUM_PLANE_REGS = 6;
  localparam int unsigned AFC_ADDR_W         = 6;
  localparam int unsigned AFC_IDX_W          = 3;
  localparam int unsigned AFC_DATA_W         = 64;
  localparam int unsigned AFC_PROD_W         = 32;
  localparam int unsigned AFC_SUM_W          = 34;
  localparam int unsigned AFC_COUNT_W        = 17;
  localparam logic [AFC_COUNT_W-1:0] AFC_COUNT_MAX = 17'd65536;

  // Packed plane register: distance in the top 16 bits, nx in the bottom 16.
  typedef struct packed {
    logic signed [AFC_COORD_W-1:0] distance;
    logic signed [AFC_COORD_W-1:0] nz;
    logic signed [AFC_COORD_W-1:0] ny;
    logic signed [AFC_COORD_W-1:0] nx;
  } afc_plane_t;

  // One box as it travels down the chain, with the visibility found so far.
  typedef struct packed {
    logic signed [AFC_COORD_W-1:0] min_x;
    logic signed [AFC_COORD_W-1:0] min_y;
    logic signed [AFC_COORD_W-1:0] min_z;
    logic signed [AFC_COORD_W-1:0] max_x;
    logic signed [AFC_COORD_W-1:0] max_y;
    logic signed [AFC_COORD_W-1:0] max_z;
    logic [1:0]                    material;
    logic                          frame_start;
    logic                          visible;
  } afc_box_t;

endpackage

// File: design/aabb_frustum_cull.sv
// Frustum culling of axis-aligned boxes by the positive-vertex test. Each input
// transfer carries one box (min and max corner, signed 16-bit quarter units), a
// two-bit material tag and a frame-start flag; each produces exactly one output
// transfer in order with the visible flag, the tag and the running count of
// visible boxes (restarted by frame start, saturating at 65536). The planes are
// six 64-bit registers at byte addresses 0, 8, ... 40 of the APB port, packed as
// distance, nz, ny, nx from the top down; normals are Q1.14 and the test is exact.
// The block takes one box per clock cycle while in_stall_o is low. A box passes
// through a chain of NUM_PLANES cells of two stages each, a multiply stage and
// an add stage, and then the output register, whose result can transfer once
// the output is not stalled. Planes beyond the sixth never reject. Write the
// planes only while no box is in flight.
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [AFC_ADDR_W-1:0]        paddr,
  input  logic [AFC_DATA_W-1:0]        pwdata,
  output logic [AFC_DATA_W-1:0]        prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [AFC_COORD_W-1:0] box_min_x_i,
  input  logic signed [AFC_COORD_W-1:0] box_min_y_i,
  input  logic signed [AFC_COORD_W-1:0] box_min_z_i,
  input  logic signed [AFC_COORD_W-1:0] box_max_x_i,
  input  logic signed [AFC_COORD_W-1:0] box_max_y_i,
  input  logic signed [AFC_COORD_W-1:0] box_max_z_i,
  input  logic [1:0]                   material_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         visible_o,
  output logic [1:0]                   material_out_o,
  output logic [AFC_COUNT_W-1:0]       in_view_count_o
);

  afc_plane_t planes [AFC_NUM_PLANE_REGS];
  afc_plane_t cell_plane [NUM_PLANES];

  // Stage k of these arrays is the input of cell k; the last entry feeds the
  // output register.
  logic     stage_valid [NUM_PLANES+1];
  logic     stage_ready [NUM_PLANES+1];
  afc_box_t stage_box   [NUM_PLANES+1];

  afc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .planes_o (planes)
  );

  // A box enters the chain assumed visible; each cell can only clear the flag.
  always_comb begin
    stage_box[0].min_x       = box_min_x_i;
    stage_box[0].min_y       = box_min_y_i;
    stage_box[0].min_z       = box_min_z_i;
    stage_box[0].max_x       = box_max_x_i;
    stage_box[0].max_y       = box_max_y_i;
    stage_box[0].max_z       = box_max_z_i;
    stage_box[0].material    = material_i;
    stage_box[0].frame_start = frame_start_i;
    stage_box[0].visible     = 1'b1;
  end

  assign stage_valid[0] = in_valid_i;
  assign in_stall_o     = !stage_ready[0];

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    // Plane slots past the register file are all zero, which never rejects.
    if (i < AFC_NUM_PLANE_REGS) begin : g_reg
      assign cell_plane[i] = planes[i];
    end else begin : g_zero
      assign cell_plane[i] = '0;
    end

    afc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .plane_i (cell_plane[i]),
      .valid_i (stage_valid[i]),
      .box_i   (stage_box[i]),
      .ready_o (stage_ready[i]),
      .valid_o (stage_valid[i+1]),
      .box_o   (stage_box[i+1]),
      .ready_i (stage_ready[i+1])
    );
  end

  // The output register holds the count and the finished result; while a result
  // waits to be taken, the chain backs up behind it.
  afc_count u_count (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (stage_valid[NUM_PLANES]),
    .box_i           (stage_box[NUM_PLANES]),
    .ready_o         (stage_ready[NUM_PLANES]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .visible_o       (visible_o),
    .material_out_o  (material_out_o),
    .in_view_count_o (in_view_count_o)
  );

endmodule

// File: design/afc_cfg.sv
module afc_cfg
  import afc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AFC_ADDR_W-1:0] paddr,
  input  logic [AFC_DATA_W-1:0] pwdata,
  output logic [AFC_DATA_W-1:0] prdata,
  output logic                  pready,
  output afc_plane_t            planes_o [AFC_NUM_PLANE_REGS]
);

  afc_plane_t           planes_q [AFC_NUM_PLANE_REGS];
  logic [AFC_IDX_W-1:0] index;
  logic                 in_range;
  logic                 wr_en;

  // Registers sit on 8-byte boundaries, so the low three address bits are ignored.
  assign index    = paddr[AFC_ADDR_W-1:3];
  assign in_range = index < AFC_IDX_W'(AFC_NUM_PLANE_REGS);
  assign wr_en    = psel && penable && pwrite && in_range;
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AFC_NUM_PLANE_REGS; i++) begin
        planes_q[i] <= '0;
      end
    end else if (wr_en) begin
      planes_q[index] <= afc_plane_t'(pwdata);
    end
  end

  always_comb begin
    prdata = '0;
    if (in_range) begin
      prdata = planes_q[index];
    end
  end

  assign planes_o = planes_q;

endmodule

// File: design/afc_cell.sv
module afc_cell
  import afc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  afc_plane_t plane_i,
  input  logic       valid_i,
  input  afc_box_t   box_i,
  output logic       ready_o,
  output logic       valid_o,
  output afc_box_t   box_o,
  input  logic       ready_i
);

  // First stage: pick the positive vertex and form the three products.
  logic                          a_valid_q;
  logic                          a_ready;
  afc_box_t                      a_box_q;
  logic signed [AFC_PROD_W-1:0]  a_px_q, a_py_q, a_pz_q;
  logic signed [AFC_COORD_W-1:0] a_dist_q;
  logic signed [AFC_COORD_W-1:0] cx, cy, cz;
  logic signed [AFC_PROD_W-1:0]  px_d, py_d, pz_d;

  // Second stage: add the distance and fold the sign into the visible flag.
  logic                 b_valid_q;
  logic                 b_ready;
  afc_box_t             b_box_q;
  afc_box_t             b_box_d;
  logic [AFC_SUM_W-1:0] sum;

  assign a_ready = !a_valid_q || b_ready;
  assign b_ready = !b_valid_q || ready_i;
  assign ready_o = a_ready;

  always_comb begin
    cx   = (plane_i.nx > 0) ? box_i.max_x : box_i.min_x;
    cy   = (plane_i.ny > 0) ? box_i.max_y : box_i.min_y;
    cz   = (plane_i.nz > 0) ? box_i.max_z : box_i.min_z;
    px_d = plane_i.nx * cx;
    py_d = plane_i.ny * cy;
    pz_d = plane_i.nz * cz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_box_q  <= box_i;
      a_px_q   <= px_d;
      a_py_q   <= py_d;
      a_pz_q   <= pz_d;
      a_dist_q <= plane_i.distance;
    end
  end

  assign sum = {{(AFC_SUM_W-AFC_PROD_W){a_px_q[AFC_PROD_W-1]}}, a_px_q}
             + {{(AFC_SUM_W-AFC_PROD_W){a_py_q[AFC_PROD_W-1]}}, a_py_q}
             + {{(AFC_SUM_W-AFC_PROD_W){a_pz_q[AFC_PROD_W-1]}}, a_pz_q}
             + {{(AFC_SUM_W-AFC_COORD_W-14){a_dist_q[AFC_COORD_W-1]}}, a_dist_q, 14'b0};

  always_comb begin
    b_box_d         = a_box_q;
    b_box_d.visible = a_box_q.visible && !sum[AFC_SUM_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_box_q <= b_box_d;
    end
  end

  assign valid_o = b_valid_q;
  assign box_o   = b_box_q;

endmodule

// File: design/afc_count.sv
module afc_count
  import afc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  afc_box_t               box_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   visible_o,
  output logic [1:0]             material_out_o,
  output logic [AFC_COUNT_W-1:0] in_view_count_o
);

  logic                   valid_q;
  logic                   take;
  logic                   visible_q;
  logic [1:0]             material_q;
  logic [AFC_COUNT_W-1:0] count_q, count_d;

  assign ready_o = !valid_q || !out_stall_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    count_d = count_q;
    if (box_i.frame_start) begin
      count_d = {{(AFC_COUNT_W-1){1'b0}}, box_i.visible};
    end else if (box_i.visible && (count_q < AFC_COUNT_MAX)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      visible_q  <= box_i.visible;
      material_q <= box_i.material;
    end
  end

  // The running count only moves when a new result is loaded, so it doubles
  // as the held count of the result on display.
  assign out_valid_o     = valid_q;
  assign visible_o       = visible_q;
  assign material_out_o  = material_q;
  assign in_view_count_o = count_q;

endmodule

// File: design/afc_checker.sv
`include "aabb_frustum_cull_defines.svh"

module afc_checker
  import afc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic                   visible_o,
  input logic [1:0]             material_out_o,
  input logic [AFC_COUNT_W-1:0] in_view_count_o
);

  `AFC_ASSERT_NXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)

  `AFC_ASSERT_NXT(a_out_payload_holds, out_valid_o && out_stall_i, $stable(visible_o) && $stable(material_out_o) && $stable(in_view_count_o))

  // A visible box always leaves a count of at least one.
  `AFC_ASSERT_IMP(a_visible_counts, out_valid_o && visible_o, in_view_count_o != '0)

  // From one result to the next the count grows by at most the visible flag.
  `AFC_ASSERT_IMP(a_count_step, (out_valid_o && !out_stall_i) ##1 out_valid_o, {1'b0, in_view_count_o} <= ({1'b0, $past(in_view_count_o)} + {{AFC_COUNT_W{1'b0}}, visible_o}))

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (.*);
